// ===== rtl/block_rms_level_meter_defines.svh =====
// Assertion macros shared by the checker of the RMS level meter.
// No dependencies; included by files that assert.
`ifndef BLOCK_RMS_LEVEL_METER_DEFINES_SVH
`define BLOCK_RMS_LEVEL_METER_DEFINES_SVH

// same-cycle implication
`define RMS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RMS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rms_pkg.sv =====
// Types and constants of the RMS level meter.
// No dependencies; used by rms_mul, the top level, the checker and the testbench.
package rms_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 16;
   localparam int FS_W       = 16;
   localparam int KEEP_W     = 9;
   localparam int MUL_W      = 16;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int QUO_W      = 30;
   localparam int ROOT_W     = QUO_W / 2;
   localparam int VOL_STEPS  = 16;
   localparam int ACC_W      = 25;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_KEEP = 1'b1;

   localparam logic [FS_W-1:0]    FS_RESET   = 16'd11141;
   localparam logic [KEEP_W-1:0]  KEEP_RESET = 9'd179;
   localparam logic [KEEP_W-1:0]  KEEP_ONE   = 9'd256;
   localparam logic [ACC_W-1:0]   ROUND_HALF = 25'd128;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 16'hFFFF;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] smoothed_level;
      logic [LEVEL_W-1:0] volume;
      logic [LEVEL_W-1:0] smoothed_volume;
      logic               overflow;
   } rsp_payload_type;

endpackage

// ===== rtl/rms_csub.sv =====
// Shared compare-and-subtract step of the RMS level meter.
// Used by the divide, square root and volume loops; no package use.
module rms_csub #(
   parameter int W = 18
) (
   input  logic [W-1:0] op_a,
   input  logic [W-1:0] op_b,
   output logic         ge,
   output logic [W-1:0] diff
);

   logic [W:0] wide;

   assign wide = {1'b0, op_a} - {1'b0, op_b};
   assign ge   = ~wide[W];
   assign diff = wide[W-1:0];

endmodule

// ===== rtl/rms_mul.sv =====
// Shared registered 16x16 unsigned multiplier of the RMS level meter.
// Depends on rms_pkg for widths.
module rms_mul (
   input  logic                       clock,
   input  logic [rms_pkg::MUL_W-1:0]  mul_a,
   input  logic [rms_pkg::MUL_W-1:0]  mul_b,
   output logic [rms_pkg::PROD_W-1:0] mul_p
);

   logic [rms_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= rms_pkg::PROD_W'(mul_a) * rms_pkg::PROD_W'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

// ===== rtl/block_rms_level_meter.sv =====
// Top level of the RMS level meter: sequencer, state and config registers.
// Depends on rms_pkg, rms_mul and rms_csub.
//
//   channel | dir | beat
//   req_    | in  | one sample with its last flag
//   rsp_    | out | level, smoothed level, two volumes, overflow
//   csr_    | in  | register index and write data, always ready
//
// A sample not flagged last is squared in the shared multiplier, then
// accumulated. A last sample then also passes the bit-serial divide, the
// square root and two volume divides on one compare-subtract unit.
// Reset is synchronous; no clearing pass. A finished result waits in the
// output register; the next item is taken meanwhile, and the block only
// holds at its end if the previous result is still not taken.
module block_rms_level_meter #(
   parameter int MAX_BLOCK = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  rms_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rms_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rms_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W    = 30 + CNT_W;
   localparam int REM_W    = (CNT_W + 1 > 16) ? CNT_W + 1 : 16;
   localparam int ALU_W    = (CNT_W + 2 > 18) ? CNT_W + 2 : 18;
   localparam int STEP_MAX = (SUM_W > rms_pkg::VOL_STEPS) ? SUM_W : rms_pkg::VOL_STEPS;
   localparam int STEP_W   = $clog2(STEP_MAX + 1);
   localparam int LW       = rms_pkg::LEVEL_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACC, ST_DIV, ST_SQRT, ST_SM_MUL0, ST_SM_MUL1, ST_SM_ADD,
      ST_VCHK, ST_VDIV, ST_OUT
   } state_type;

   state_type                       state_ff, state_in;
   logic [rms_pkg::FS_W-1:0]        fs_ff, fs_in;
   logic [rms_pkg::KEEP_W-1:0]      keep_ff, keep_in;
   logic                            last_ff, last_in;
   logic                            take_ff, take_in;
   logic [SUM_W-1:0]                sum_ff, sum_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [LW-1:0]                   smooth_ff, smooth_in;
   logic                            ovf_ff, ovf_in;
   logic [REM_W-1:0]                rem_ff, rem_in;
   logic [SUM_W-1:0]                dq_ff, dq_in;
   logic [rms_pkg::QUO_W-1:0]       sqv_ff, sqv_in;
   logic [rms_pkg::ROOT_W-1:0]      root_ff, root_in;
   logic [LW-1:0]                   lvl_ff, lvl_in;
   logic [rms_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic                            vsel_ff, vsel_in;
   logic [LW-1:0]                   vq_ff, vq_in;
   logic [LW-1:0]                   vol_ff, vol_in;
   logic [LW-1:0]                   vols_ff, vols_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rms_pkg::rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   logic [rms_pkg::MUL_W-1:0]       mul_a, mul_b;
   logic [rms_pkg::PROD_W-1:0]      mul_p;
   logic [ALU_W-1:0]                alu_a, alu_b, alu_diff;
   logic                            alu_ge;

   logic [rms_pkg::SAMPLE_W-1:0]    sample_u, mag;
   logic [rms_pkg::KEEP_W-1:0]      keep_eff;
   logic [rms_pkg::FS_W-1:0]        fs_eff;
   logic [LW-1:0]                   vin;
   logic                            req_take;

   rms_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   rms_csub #(.W(ALU_W)) u_csub (
      .op_a (alu_a),
      .op_b (alu_b),
      .ge   (alu_ge),
      .diff (alu_diff)
   );

   assign sample_u  = req_payload.sample;
   assign mag       = sample_u[rms_pkg::SAMPLE_W-1] ? (~sample_u + 16'd1) : sample_u;
   assign keep_eff  = (keep_ff > rms_pkg::KEEP_ONE) ? rms_pkg::KEEP_ONE : keep_ff;
   assign fs_eff    = (fs_ff == '0) ? 16'd1 : fs_ff;
   assign vin       = vsel_ff ? smooth_ff : lvl_ff;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         ST_IDLE: begin
            mul_a = mag;
            mul_b = mag;
         end
         ST_SM_MUL0: begin
            mul_a = rms_pkg::MUL_W'(keep_eff);
            mul_b = smooth_ff;
         end
         ST_SM_MUL1: begin
            mul_a = rms_pkg::MUL_W'(rms_pkg::KEEP_ONE - keep_eff);
            mul_b = lvl_ff;
         end
         ST_DIV: begin
            alu_a = ALU_W'({rem_ff[CNT_W:0], dq_ff[SUM_W-1]});
            alu_b = ALU_W'({count_ff, 1'b0});
         end
         ST_SQRT: begin
            alu_a = ALU_W'({rem_ff[15:0], sqv_ff[rms_pkg::QUO_W-1 -: 2]});
            alu_b = ALU_W'({root_ff, 2'b01});
         end
         ST_VCHK: begin
            alu_a = ALU_W'(vin);
            alu_b = ALU_W'(fs_eff);
         end
         ST_VDIV: begin
            alu_a = ALU_W'({rem_ff[15:0], 1'b0});
            alu_b = ALU_W'(fs_eff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      logic [SUM_W-1:0]          sum_add;
      logic [SUM_W-1:0]          dq_next;
      logic [rms_pkg::ROOT_W-1:0] root_next;
      logic [LW-1:0]             vq_next;
      logic [rms_pkg::ACC_W-1:0] acc_sum;
      logic [LW-1:0]             vres;
      logic                      vdone;

      state_in       = state_ff;
      fs_in          = fs_ff;
      keep_in        = keep_ff;
      last_in        = last_ff;
      take_in        = take_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      smooth_in      = smooth_ff;
      ovf_in         = ovf_ff;
      rem_in         = rem_ff;
      dq_in          = dq_ff;
      sqv_in         = sqv_ff;
      root_in        = root_ff;
      lvl_in         = lvl_ff;
      acc_in         = acc_ff;
      vsel_in        = vsel_ff;
      vq_in          = vq_ff;
      vol_in         = vol_ff;
      vols_in        = vols_ff;
      step_in        = step_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      sum_add   = sum_ff + (take_ff ? SUM_W'(mul_p) : '0);
      dq_next   = {dq_ff[SUM_W-2:0], alu_ge};
      root_next = {root_ff[rms_pkg::ROOT_W-2:0], alu_ge};
      vq_next   = {vq_ff[LW-2:0], alu_ge};
      acc_sum   = acc_ff + rms_pkg::ACC_W'(mul_p);
      vres      = vq_next;
      vdone     = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            rms_pkg::CSR_FULL_SCALE:  fs_in   = csr_wdata;
            rms_pkg::CSR_SMOOTH_KEEP: keep_in = csr_wdata[rms_pkg::KEEP_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               last_in  = req_payload.last;
               take_in  = (count_ff != CNT_W'(MAX_BLOCK));
               if (count_ff == CNT_W'(MAX_BLOCK)) begin
                  ovf_in = 1'b1;
               end
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            sum_in = sum_add;
            if (take_ff) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (last_ff) begin
               rem_in   = '0;
               dq_in    = sum_add;
               step_in  = STEP_W'(SUM_W);
               state_in = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            rem_in  = REM_W'(alu_ge ? alu_diff : alu_a);
            dq_in   = dq_next;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               sqv_in   = (count_ff == '0) ? '0 : rms_pkg::QUO_W'(dq_next);
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_W'(rms_pkg::ROOT_W);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rem_in  = REM_W'(alu_ge ? alu_diff : alu_a);
            root_in = root_next;
            sqv_in  = sqv_ff << 2;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               lvl_in   = LW'(root_next);
               state_in = ST_SM_MUL0;
            end
         end
         ST_SM_MUL0: begin
            state_in = ST_SM_MUL1;
         end
         ST_SM_MUL1: begin
            acc_in   = rms_pkg::ACC_W'(mul_p) + rms_pkg::ROUND_HALF;
            state_in = ST_SM_ADD;
         end
         ST_SM_ADD: begin
            smooth_in = acc_sum[LW+7:8];
            vsel_in   = 1'b0;
            state_in  = ST_VCHK;
         end
         ST_VCHK: begin
            if (alu_ge) begin
               vres  = rms_pkg::LEVEL_MAX;
               vdone = 1'b1;
            end else begin
               rem_in   = REM_W'(vin);
               vq_in    = '0;
               step_in  = STEP_W'(rms_pkg::VOL_STEPS);
               state_in = ST_VDIV;
            end
         end
         ST_VDIV: begin
            rem_in  = REM_W'(alu_ge ? alu_diff : alu_a);
            vq_in   = vq_next;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               vdone = 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_payload_in.level           = lvl_ff;
               rsp_payload_in.smoothed_level  = smooth_ff;
               rsp_payload_in.volume          = vol_ff;
               rsp_payload_in.smoothed_volume = vols_ff;
               rsp_payload_in.overflow        = ovf_ff;
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (vdone) begin
         if (!vsel_ff) begin
            vol_in   = vres;
            vsel_in  = 1'b1;
            state_in = ST_VCHK;
         end else begin
            vols_in  = vres;
            state_in = ST_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fs_ff        <= rms_pkg::FS_RESET;
         keep_ff      <= rms_pkg::KEEP_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         smooth_ff    <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fs_ff        <= fs_in;
         keep_ff      <= keep_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         smooth_ff    <= smooth_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff        <= last_in;
      take_ff        <= take_in;
      rem_ff         <= rem_in;
      dq_ff          <= dq_in;
      sqv_ff         <= sqv_in;
      root_ff        <= root_in;
      lvl_ff         <= lvl_in;
      acc_ff         <= acc_in;
      vsel_ff        <= vsel_in;
      vq_ff          <= vq_in;
      vol_ff         <= vol_in;
      vols_ff        <= vols_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ===== rtl/rms_chk.sv =====
// Port-level checker of the RMS level meter, bound to the top level.
// Depends on rms_pkg and block_rms_level_meter_defines.svh.
`include "block_rms_level_meter_defines.svh"

module rms_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input rms_pkg::rsp_payload_type       rsp_payload
);

   `RMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "result beat changed while stalled")

   `RMS_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && req_ready,
      !req_ready, "ready right after an accepted sample")

   `RMS_ASSERT_IMP(a_rsp_not_next, clock, reset, $rose(rsp_valid),
      !$past(req_valid && req_ready), "result right after an accepted sample")

   `RMS_ASSERT_IMP(a_zero_volume, clock, reset, rsp_valid && (rsp_payload.level == 16'd0),
      rsp_payload.volume == 16'd0, "nonzero volume for zero level")

endmodule

bind block_rms_level_meter rms_chk u_rms_chk (.*);

// ===== tb/block_rms_level_meter_test.sv =====
// Testbench for block_rms_level_meter: sample beats in, block level beats out,
// checked against a scoreboard that predicts each level. Depends on rms_pkg.
// Runs directed blocks, then random blocks under several register settings.
module block_rms_level_meter_test;
   import rms_pkg::*;

   localparam int BLOCK_LIMIT   = 256;
   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASE_ITEMS   = 65;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   class level_scoreboard;
      logic [FS_W-1:0]      fs_reg   = FS_RESET;
      logic [KEEP_W-1:0]    keep_reg = KEEP_RESET;
      longint unsigned      square_acc;
      int                   block_count;
      logic [LEVEL_W-1:0]   smooth_reg = '0;
      bit                   dropped;
      int                   errors;
      rsp_payload_type      pending_levels[$];

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_FULL_SCALE) begin
            fs_reg = data;
         end else if (idx == CSR_SMOOTH_KEEP) begin
            keep_reg = data[KEEP_W-1:0];
         end
      endfunction

      function longint unsigned floor_root(longint unsigned v);
         longint unsigned r;
         longint unsigned trial;
         r = 0;
         for (int b = 20; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) r = trial;
         end
         return r;
      endfunction

      function logic [LEVEL_W-1:0] to_volume(logic [LEVEL_W-1:0] lvl);
         longint unsigned fs;
         longint unsigned v;
         fs = (fs_reg == '0) ? 1 : longint'(fs_reg);
         v = (longint'(lvl) << 16) / fs;
         return (v > 65535) ? LEVEL_MAX : v[LEVEL_W-1:0];
      endfunction

      function void take_sample(req_payload_type p);
         int s;
         longint unsigned mag;
         longint unsigned root;
         longint unsigned keep;
         longint unsigned acc;
         rsp_payload_type lvl;
         s = p.sample;
         mag = (s < 0) ? -s : s;
         if (block_count < BLOCK_LIMIT) begin
            square_acc += mag * mag;
            block_count++;
         end else begin
            dropped = 1'b1;
         end
         if (!p.last) return;
         root = 0;
         if (block_count != 0)
            root = floor_root(square_acc / (longint'(block_count) * 2));
         if (root > 65535) root = 65535;
         keep = (keep_reg > KEEP_ONE) ? 256 : longint'(keep_reg);
         acc = keep * smooth_reg + (256 - keep) * root + 128;
         smooth_reg = acc[23:8];
         lvl.level           = root[LEVEL_W-1:0];
         lvl.smoothed_level  = smooth_reg;
         lvl.volume          = to_volume(root[LEVEL_W-1:0]);
         lvl.smoothed_volume = to_volume(smooth_reg);
         lvl.overflow        = dropped;
         pending_levels.push_back(lvl);
         square_acc  = 0;
         block_count = 0;
         dropped     = 1'b0;
      endfunction

      function void field_check(string name, logic [LEVEL_W-1:0] exp_v,
                                logic [LEVEL_W-1:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v,
                     act_v);
         end
      endfunction

      function void check_level(rsp_payload_type act);
         rsp_payload_type exp_l;
         if (pending_levels.size() == 0) begin
            errors++;
            $display("%0t: unexpected level beat, expected none actual %p", $time, act);
            return;
         end
         exp_l = pending_levels.pop_front();
         field_check("level", exp_l.level, act.level);
         field_check("smoothed_level", exp_l.smoothed_level, act.smoothed_level);
         field_check("volume", exp_l.volume, act.volume);
         field_check("smoothed_volume", exp_l.smoothed_volume, act.smoothed_volume);
         field_check("overflow", 16'(exp_l.overflow), 16'(act.overflow));
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   idle_mode_type          idle_mode   = IDLE_NONE;
   int                     cycle_count = 0;
   int                     sent        = 0;
   level_scoreboard        meter       = new();

   block_rms_level_meter #(.MAX_BLOCK(BLOCK_LIMIT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("block_rms_level_meter regression: fail");
         $finish;
      end
   end

   // result side: check accepted beats, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) meter.check_level(rsp_payload);
      case (idle_mode)
         IDLE_RECEIVER: rsp_ready <= ($urandom_range(99) >= 86);
         IDLE_BOTH:     rsp_ready <= ($urandom_range(99) >= 24);
         default:       rsp_ready <= 1'b1;
      endcase
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 10) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      if (r < 30) return SAMPLE_W'(int'($urandom_range(510)) - 255);
      if (r < 35) return '0;
      return SAMPLE_W'($urandom());
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
      int gap;
      int pct;
      gap = 0;
      pct = (idle_mode == IDLE_SENDER) ? 86 : (idle_mode == IDLE_BOTH) ? 24 : 0;
      while ($urandom_range(99) < pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= {s, l};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      meter.take_sample(req_payload);
      sent++;
   endtask

   task automatic send_block(input int len);
      for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (meter.pending_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes keep one assignment per step
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      meter.set_reg(idx, data);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] fs,
                            input logic [CSR_DATA_W-1:0] keep_word,
                            input idle_mode_type mode, input bit long_block);
      int stop_at;
      int r;
      settle();
      write_reg(CSR_FULL_SCALE, fs);
      write_reg(CSR_SMOOTH_KEEP, keep_word);
      csr_valid <= 1'b0;
      idle_mode = mode;
      stop_at = sent + PHASE_ITEMS;
      if (long_block) send_block($urandom_range(BLOCK_LIMIT, BLOCK_LIMIT + 8));
      while (sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 15) send_sample(pick_sample(), $urandom_range(1));
         else if (r < 95) send_block($urandom_range(1, 8));
         else send_block($urandom_range(9, 48));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset register values
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh0000, 1'b1);
      send_sample(16'sh0001, 1'b1);
      send_sample(16'shFFFF, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh0005, 1'b0);
      send_sample(-16'sd7, 1'b0);
      send_sample(16'sh0064, 1'b1);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shAAAA, 1'b1);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh0000, 1'b1);

      run_phase(16'hFFFF, 16'd0, IDLE_SENDER, 1'b1);
      run_phase(16'd1, 16'd256, IDLE_RECEIVER, 1'b0);
      run_phase(16'd0, 16'hFFFF, IDLE_BOTH, 1'b0);
      run_phase(CSR_DATA_W'($urandom_range(1, 65535)), CSR_DATA_W'($urandom_range(0, 256)),
                IDLE_NONE, 1'b1);
      run_phase(CSR_DATA_W'($urandom_range(1, 65535)), CSR_DATA_W'($urandom()),
                IDLE_BOTH, 1'b0);
      run_phase(FS_RESET, CSR_DATA_W'(KEEP_RESET), IDLE_RECEIVER, 1'b0);

      settle();
      if (meter.errors == 0) begin
         $display("block_rms_level_meter regression: pass");
      end else begin
         $display("block_rms_level_meter regression: fail");
      end
      $finish;
   end

endmodule
